// ----- hdl/lbvt_pkg.sv -----
`timescale 1ns / 1ps
package lbvt_pkg;

   localparam int TABLES       = 4;
   localparam int KEY_BITS     = 8;
   localparam int BUCKET_SLOTS = 8;
   localparam int MAX_ITEMS    = 1024;

   // fixed field widths
   localparam int CMD_W  = 2;
   localparam int TBL_W  = 2;
   localparam int KEY_W  = 8;
   localparam int ID_W   = 10;
   localparam int VOTE_W = 8;
   localparam int STAT_W = 2;

   localparam int KEY_COUNT = 1 << KEY_BITS;
   localparam int TBL_AW    = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int BKT_AW    = TBL_AW + KEY_BITS;
   localparam int BKT_DEPTH = TABLES * KEY_COUNT;
   localparam int SLOT_AW   = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
   localparam int ENT_AW    = BKT_AW + SLOT_AW;
   localparam int ENT_DEPTH = BKT_DEPTH * BUCKET_SLOTS;
   localparam int FILL_W    = $clog2(BUCKET_SLOTS + 1);
   localparam int ITEM_AW   = $clog2(MAX_ITEMS);
   localparam int CUR_W     = ITEM_AW + 1;
   localparam int SWEEP_AW  = (BKT_AW > ITEM_AW) ? BKT_AW : ITEM_AW;
   localparam int SWEEP_LAST = ((BKT_DEPTH > MAX_ITEMS) ? BKT_DEPTH : MAX_ITEMS) - 1;
   localparam int VOTE_MAX  = 255;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int THRESHOLD_RESET = 2;

   typedef enum logic [CSR_AW-3:0] {
      REG_THRESHOLD = 1'b0
   } reg_index_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_FETCH  = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_NONE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_Q_RD,
      ST_Q_CHK,
      ST_Q_ENT,
      ST_Q_VRD,
      ST_Q_VWR,
      ST_F_SCAN,
      ST_SWEEP_V,
      ST_SWEEP_F,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [TBL_W-1:0] table_index;
      logic [KEY_W-1:0] bucket_key;
      logic [ID_W-1:0]  item_id;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   found_id;
      logic [VOTE_W-1:0] found_votes;
   } rsp_type;

endpackage

// ----- hdl/lsh_bucket_vote_table.sv -----
`timescale 1ns / 1ps
// Multi-table LSH bucket store with per-item vote counting. Inserts append
// an id to a bucket (status 1 when the bucket is full), a query key votes
// once per round for every id in its bucket, each fetch returns the next id
// in ascending order with votes above vote_threshold, and the fetch that
// finds none ends the round (status 2) and clears votes and visited marks.
// One transaction at a time. A fetch scans the vote memory from the round
// cursor, one entry per cycle. A fetch miss adds a clearing pass over vote
// and visited memories, and clear runs a pass over the fill memory. After
// reset a clearing pass runs before the first transaction is taken;
// configuration writes are taken at any time. A result sits in an output
// register, so the engine is released as soon as the result is handed off.
module lsh_bucket_vote_table
   import lbvt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   input  req_type           req_data,
   output logic              req_stall,
   // response channel
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              rsp_stall,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [VOTE_W-1:0] thr_ff, thr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              out_free, eng_valid;
   rsp_type           eng_data;
   reg_index_type     csr_idx;

   // register file: one threshold register at byte address 0
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_idx == REG_THRESHOLD) ? CSR_DW'(thr_ff) : '0;

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_idx == REG_THRESHOLD)) begin
         thr_in = csr_pwdata[VOTE_W-1:0];
      end
   end

   lbvt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .threshold (thr_ff),
      .res_ready (out_free),
      .res_valid (eng_valid),
      .res_data  (eng_data)
   );

   // output register: takes a new result whenever empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = eng_valid;
         if (eng_valid) rsp_data_in = eng_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= VOTE_W'(THRESHOLD_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/lbvt_ram.sv -----
`timescale 1ns / 1ps
module lbvt_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- hdl/lbvt_engine.sv -----
`timescale 1ns / 1ps
module lbvt_engine
   import lbvt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  req_type           req_data,
   output logic              req_stall,
   input  logic [VOTE_W-1:0] threshold,
   input  logic              res_ready,
   output logic              res_valid,
   output rsp_type           res_data
);

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [BKT_AW-1:0]   bkt_ff, bkt_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [FILL_W-1:0]   n_ff, n_in;
   logic [FILL_W-1:0]   slot_ff, slot_in;
   logic [ITEM_AW-1:0]  e_ff, e_in;
   logic [CUR_W-1:0]    scan_ff, scan_in;
   logic                pv_ff, pv_in;
   logic [ITEM_AW-1:0]  addr_d_ff, addr_d_in;
   logic [CUR_W-1:0]    cursor_ff, cursor_in;
   logic [SWEEP_AW-1:0] cnt_ff, cnt_in;
   rsp_type             res_ff, res_in;

   logic                fill_we, vis_we, ent_we, vote_we;
   logic [BKT_AW-1:0]   fill_waddr, vis_waddr;
   logic [FILL_W-1:0]   fill_wdata, fill_rdata;
   logic                vis_wdata, vis_rdata;
   logic [ENT_AW-1:0]   ent_waddr, ent_raddr;
   logic [ID_W-1:0]     ent_wdata, ent_rdata;
   logic [ITEM_AW-1:0]  vote_waddr, vote_raddr;
   logic [VOTE_W-1:0]   vote_wdata, vote_rdata;

   logic accept, tbl_ok, sweep_done, slot_last, fill_room, e_ok, scan_end, hit;
   logic [BKT_AW-1:0] req_bkt;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign tbl_ok     = 32'(req_data.table_index) < 32'(TABLES);
   assign req_bkt    = (BKT_AW'(req_data.table_index) << KEY_BITS)
                     | BKT_AW'(req_data.bucket_key[KEY_BITS-1:0]);
   assign sweep_done = cnt_ff == SWEEP_AW'(SWEEP_LAST);
   assign slot_last  = (slot_ff + FILL_W'(1)) == n_ff;
   assign fill_room  = fill_rdata < FILL_W'(BUCKET_SLOTS);
   assign e_ok       = 32'(ent_rdata) < 32'(MAX_ITEMS);
   assign scan_end   = scan_ff == CUR_W'(MAX_ITEMS);
   assign hit        = pv_ff && (vote_rdata > threshold);

   lbvt_ram #(.DEPTH(BKT_DEPTH), .AW(BKT_AW), .DW(FILL_W)) u_fill (
      .clock(clock), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
      .raddr(bkt_ff), .rdata(fill_rdata));

   lbvt_ram #(.DEPTH(BKT_DEPTH), .AW(BKT_AW), .DW(1)) u_visited (
      .clock(clock), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
      .raddr(bkt_ff), .rdata(vis_rdata));

   lbvt_ram #(.DEPTH(ENT_DEPTH), .AW(ENT_AW), .DW(ID_W)) u_entries (
      .clock(clock), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
      .raddr(ent_raddr), .rdata(ent_rdata));

   lbvt_ram #(.DEPTH(MAX_ITEMS), .AW(ITEM_AW), .DW(VOTE_W)) u_votes (
      .clock(clock), .we(vote_we), .waddr(vote_waddr), .wdata(vote_wdata),
      .raddr(vote_raddr), .rdata(vote_rdata));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: if (sweep_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               case (cmd_type'(req_data.cmd))
                  CMD_INSERT: state_in = tbl_ok ? ST_INS_RD : ST_RESP;
                  CMD_QUERY:  state_in = tbl_ok ? ST_Q_RD : ST_RESP;
                  CMD_FETCH:  state_in = ST_F_SCAN;
                  default:    state_in = ST_SWEEP_F;
               endcase
            end
         end
         ST_INS_RD: state_in = ST_INS_WR;
         ST_INS_WR: state_in = ST_RESP;
         ST_Q_RD:   state_in = ST_Q_CHK;
         ST_Q_CHK: begin
            if (vis_rdata || (fill_rdata == '0)) state_in = ST_RESP;
            else state_in = ST_Q_ENT;
         end
         ST_Q_ENT: state_in = ST_Q_VRD;
         ST_Q_VRD: begin
            if (e_ok) state_in = ST_Q_VWR;
            else state_in = slot_last ? ST_RESP : ST_Q_ENT;
         end
         ST_Q_VWR: state_in = slot_last ? ST_RESP : ST_Q_ENT;
         ST_F_SCAN: begin
            if (hit) state_in = ST_RESP;
            else if (!pv_ff && scan_end) state_in = ST_SWEEP_V;
         end
         ST_SWEEP_V: if (sweep_done) state_in = ST_RESP;
         ST_SWEEP_F: if (sweep_done) state_in = ST_RESP;
         ST_RESP:    if (res_ready) state_in = ST_IDLE;
         default:    state_in = ST_INIT;
      endcase
   end

   // memory ports and handshake
   always_comb begin
      req_stall  = state_ff != ST_IDLE;
      res_valid  = state_ff == ST_RESP;
      fill_we    = 1'b0;
      fill_waddr = cnt_ff[BKT_AW-1:0];
      fill_wdata = '0;
      vis_we     = 1'b0;
      vis_waddr  = cnt_ff[BKT_AW-1:0];
      vis_wdata  = 1'b0;
      ent_we     = 1'b0;
      ent_waddr  = ENT_AW'(bkt_ff) * ENT_AW'(BUCKET_SLOTS) + ENT_AW'(fill_rdata);
      ent_wdata  = id_ff;
      ent_raddr  = ENT_AW'(bkt_ff) * ENT_AW'(BUCKET_SLOTS) + ENT_AW'(slot_ff);
      vote_we    = 1'b0;
      vote_waddr = cnt_ff[ITEM_AW-1:0];
      vote_wdata = '0;
      vote_raddr = (state_ff == ST_Q_VRD) ? ITEM_AW'(ent_rdata) : scan_ff[ITEM_AW-1:0];
      case (state_ff)
         ST_INIT: begin
            fill_we = 1'b1;
            vis_we  = 1'b1;
            vote_we = 1'b1;
         end
         ST_INS_WR: begin
            if (fill_room) begin
               ent_we     = 1'b1;
               fill_we    = 1'b1;
               fill_waddr = bkt_ff;
               fill_wdata = fill_rdata + FILL_W'(1);
            end
         end
         ST_Q_CHK: begin
            if (!vis_rdata) begin
               vis_we    = 1'b1;
               vis_waddr = bkt_ff;
               vis_wdata = 1'b1;
            end
         end
         ST_Q_VWR: begin
            if (vote_rdata != VOTE_W'(VOTE_MAX)) begin
               vote_we    = 1'b1;
               vote_waddr = e_ff;
               vote_wdata = vote_rdata + VOTE_W'(1);
            end
         end
         ST_SWEEP_V: begin
            vis_we  = 1'b1;
            vote_we = 1'b1;
         end
         ST_SWEEP_F: fill_we = 1'b1;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      cmd_in    = cmd_ff;
      bkt_in    = bkt_ff;
      id_in     = id_ff;
      n_in      = n_ff;
      slot_in   = slot_ff;
      e_in      = e_ff;
      scan_in   = scan_ff;
      pv_in     = pv_ff;
      addr_d_in = addr_d_ff;
      cursor_in = cursor_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      case (state_ff)
         ST_INIT: cnt_in = cnt_ff + SWEEP_AW'(1);
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = cmd_type'(req_data.cmd);
               bkt_in  = req_bkt;
               id_in   = req_data.item_id;
               scan_in = cursor_ff;
               pv_in   = 1'b0;
               cnt_in  = '0;
               res_in  = '0;
            end
         end
         ST_INS_WR: if (!fill_room) res_in.status = STAT_FULL;
         ST_Q_CHK: begin
            n_in    = fill_rdata;
            slot_in = '0;
         end
         ST_Q_VRD: begin
            e_in = ITEM_AW'(ent_rdata);
            if (!e_ok) slot_in = slot_ff + FILL_W'(1);
         end
         ST_Q_VWR: slot_in = slot_ff + FILL_W'(1);
         ST_F_SCAN: begin
            pv_in = !scan_end;
            if (!scan_end) begin
               scan_in   = scan_ff + CUR_W'(1);
               addr_d_in = scan_ff[ITEM_AW-1:0];
            end
            if (hit) begin
               res_in.found_id    = ID_W'(addr_d_ff);
               res_in.found_votes = vote_rdata;
               cursor_in          = CUR_W'(addr_d_ff) + CUR_W'(1);
            end else if (!pv_ff && scan_end) begin
               res_in.status = STAT_NONE;
            end
         end
         ST_SWEEP_V: begin
            cnt_in    = cnt_ff + SWEEP_AW'(1);
            cursor_in = '0;
         end
         ST_SWEEP_F: cnt_in = cnt_ff + SWEEP_AW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         cnt_ff    <= '0;
         cursor_ff <= '0;
         pv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         cursor_ff <= cursor_in;
         pv_ff     <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      bkt_ff    <= bkt_in;
      id_ff     <= id_in;
      n_ff      <= n_in;
      slot_ff   <= slot_in;
      e_ff      <= e_in;
      scan_ff   <= scan_in;
      addr_d_ff <= addr_d_in;
      res_ff    <= res_in;
   end

   assign res_data = res_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted transaction left engine idle");

   a_fetch_over_thr: assert property (@(posedge clock) disable iff (reset)
      (res_valid && cmd_ff == CMD_FETCH && res_ff.status == STAT_OK)
      |-> (res_ff.found_votes > threshold))
      else $error("fetched candidate not above threshold");

   a_nonfetch_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && cmd_ff != CMD_FETCH)
      |-> (res_ff.found_id == '0 && res_ff.found_votes == '0))
      else $error("non-fetch result carries candidate data");

   a_vote_write_inc: assert property (@(posedge clock) disable iff (reset)
      (vote_we && state_ff == ST_Q_VWR) |-> (vote_wdata != '0))
      else $error("vote increment wrapped");
`endif

endmodule

// ----- dv/lsh_bucket_vote_table_checker.sv -----
`timescale 1ns / 1ps
module lsh_bucket_vote_table_checker
   import lbvt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  req_type           req_data,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  rsp_type           rsp_data,
   input  logic              rsp_stall,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic [CSR_DW-1:0] csr_prdata,
   input  logic              csr_pready,
   output int                errors,
   output int                outstanding
);

   logic [ID_W-1:0]   slot_ids [ENT_DEPTH];
   logic [FILL_W-1:0] bucket_count [BKT_DEPTH];
   logic [VOTE_W-1:0] item_votes [MAX_ITEMS];
   bit                key_seen [BKT_DEPTH];
   int unsigned       scan_start;
   logic [VOTE_W-1:0] threshold;
   rsp_type           answers_q [$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
   endtask

   // ends a query round
   function automatic void close_round();
      foreach (item_votes[i]) item_votes[i] = '0;
      foreach (key_seen[i]) key_seen[i] = 1'b0;
      scan_start = 0;
   endfunction

   function automatic rsp_type apply_command(input req_type r);
      rsp_type a;
      int      b;
      int      n;
      int      e;
      int      i;
      bit      hit;
      a = '0;
      b = int'(r.table_index) * KEY_COUNT + int'(r.bucket_key & (KEY_COUNT - 1));
      case (cmd_type'(r.cmd))
         CMD_INSERT: begin
            if (r.table_index < TABLES) begin
               n = bucket_count[b];
               if (n < BUCKET_SLOTS) begin
                  slot_ids[b * BUCKET_SLOTS + n] = r.item_id;
                  bucket_count[b] = FILL_W'(n + 1);
               end else begin
                  a.status = STAT_FULL;
               end
            end
         end
         CMD_QUERY: begin
            if (r.table_index < TABLES && !key_seen[b]) begin
               key_seen[b] = 1'b1;
               for (int s = 0; s < bucket_count[b]; s++) begin
                  e = slot_ids[b * BUCKET_SLOTS + s];
                  if (e < MAX_ITEMS && item_votes[e] < VOTE_MAX)
                     item_votes[e] = item_votes[e] + 1'b1;
               end
            end
         end
         CMD_FETCH: begin
            hit = 1'b0;
            for (i = scan_start; i < MAX_ITEMS; i++) begin
               if (item_votes[i] > threshold) begin
                  hit = 1'b1;
                  break;
               end
            end
            if (hit) begin
               a.found_id    = ID_W'(i);
               a.found_votes = item_votes[i];
               scan_start    = i + 1;
            end else begin
               a.status = STAT_NONE;
               close_round();
            end
         end
         default: foreach (bucket_count[k]) bucket_count[k] = '0;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         foreach (bucket_count[k]) bucket_count[k] = '0;
         close_round();
         threshold = VOTE_W'(THRESHOLD_RESET);
         answers_q.delete();
         errors = 0;
      end else begin
         // results first: a result never belongs to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (answers_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: %h", rsp_data));
            end else begin
               want = answers_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.found_id !== want.found_id)
                  report_mismatch($sformatf("found_id %0d, want %0d",
                                            rsp_data.found_id, want.found_id));
               if (rsp_data.found_votes !== want.found_votes)
                  report_mismatch($sformatf("found_votes %0d, want %0d",
                                            rsp_data.found_votes, want.found_votes));
            end
         end
         if (req_valid && !req_stall)
            answers_q.insert(answers_q.size(), apply_command(req_data));
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_AW-1:2] == REG_THRESHOLD) begin
            if (csr_pwrite)
               threshold = csr_pwdata[VOTE_W-1:0];
            else if (csr_prdata !== CSR_DW'(threshold))
               report_mismatch($sformatf("threshold read %h, want %h",
                                         csr_prdata, threshold));
         end
      end
      outstanding = answers_q.size();
   end

endmodule

// ----- dv/lsh_bucket_vote_table_tb.sv -----
`timescale 1ns / 1ps
module lsh_bucket_vote_table_tb;
   import lbvt_pkg::*;

   // cycles with no transaction anywhere before giving up; the slowest
   // legal gap is a miss fetch (full scan plus clearing pass) or the reset pass
   localparam int IDLE_LIMIT = 20000;
   localparam int ITEM_BUDGET = 1700;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   req_type           req_data = '0;
   logic              req_stall;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              rsp_stall = 1'b1;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   int                errors;
   int                outstanding;
   int                sent = 0;
   int                idle_cycles = 0;
   bit                req_quiet = 1'b0;
   bit                rsp_quiet = 1'b0;

   always #1 clock = ~clock;

   lsh_bucket_vote_table dut (.*);

   lsh_bucket_vote_table_checker vote_check (.*);

   // watchdog: counts cycles in which no transaction moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("[lsh_bucket_vote_table] ERROR");
            $finish;
         end
      end
   end

   // gap draw: 0..15, with stretches of back-to-back traffic
   function automatic int draw_gap(inout bit quiet);
      if ($urandom_range(0, 63) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   // result side: stall a random number of cycles before each result
   initial begin : result_sink
      int n;
      @(negedge reset);
      forever begin
         @(negedge clock);
         n = draw_gap(rsp_quiet);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_txn(input cmd_type c, input int tbl, input int key, input int id);
      int n;
      n = draw_gap(req_quiet);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: c, table_index: TBL_W'(tbl), bucket_key: KEY_W'(key),
                     item_id: ID_W'(id)};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   // random content in every field
   task automatic send_noise();
      send_txn(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 3),
               $urandom_range(0, 255), $urandom_range(0, 1023));
   endtask

   // hold off the sender until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_access(input bit wr, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_AW'(REG_THRESHOLD) << 2;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_threshold(input int unsigned value);
      drain();
      csr_access(1'b1, value);
      csr_access(1'b0, 0);
   endtask

   // one query round on a narrow key/id window so buckets collide and votes pile up
   task automatic query_round();
      int key_base;
      int id_base;
      key_base = ($urandom_range(0, 7) == 0) ? 252 * $urandom_range(0, 1)
                                             : $urandom_range(0, 252);
      id_base  = ($urandom_range(0, 7) == 0) ? 1016 * $urandom_range(0, 1)
                                             : $urandom_range(0, 1016);
      if ($urandom_range(0, 5) == 0) send_txn(CMD_CLEAR, 0, 0, 0);
      repeat ($urandom_range(2, 24)) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         send_txn(CMD_INSERT, $urandom_range(0, 3), key_base + $urandom_range(0, 3),
                  id_base + $urandom_range(0, 7));
      end
      repeat ($urandom_range(1, 16)) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         send_txn(CMD_QUERY, $urandom_range(0, 3), key_base + $urandom_range(0, 3), 0);
      end
      // some rounds are left open on purpose
      repeat ($urandom_range(1, 10)) send_txn(CMD_FETCH, 0, 0, 0);
   endtask

   initial begin : stimulus
      int unsigned levels [4];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_access(1'b0, 0);   // reset value of the threshold

      // directed: field extremes, full bucket, repeated key, clear mid-round
      csr_access(1'b1, 0);
      send_txn(CMD_INSERT, 3, 255, 1023);
      send_txn(CMD_INSERT, 0, 0, 0);
      repeat (9) send_txn(CMD_INSERT, 1, 17, 512);   // ninth one is dropped
      send_txn(CMD_QUERY, 3, 255, 1023);
      send_txn(CMD_QUERY, 0, 0, 1023);
      send_txn(CMD_QUERY, 1, 17, 0);
      send_txn(CMD_QUERY, 1, 17, 0);                 // already visited this round
      send_txn(CMD_FETCH, 3, 255, 1023);
      send_txn(CMD_CLEAR, 2, 128, 341);              // votes survive a clear
      send_txn(CMD_QUERY, 3, 255, 0);                // empty bucket after clear
      send_txn(CMD_FETCH, 0, 0, 0);
      send_txn(CMD_FETCH, 0, 0, 0);
      send_txn(CMD_FETCH, 0, 0, 0);
      send_txn(CMD_FETCH, 0, 0, 0);

      // saturation: one id, eight copies in 32 buckets, 256 votes in one round
      set_threshold(254);
      send_txn(CMD_CLEAR, 0, 0, 0);
      for (int t = 0; t < TABLES; t++)
         for (int k = 0; k < 8; k++)
            repeat (BUCKET_SLOTS) send_txn(CMD_INSERT, t, k, 777);
      for (int t = 0; t < TABLES; t++)
         for (int k = 0; k < 8; k++)
            send_txn(CMD_QUERY, t, k, 0);
      repeat (3) send_txn(CMD_FETCH, 0, 0, 0);

      // random rounds across several thresholds, extremes included
      levels = '{1, 255, $urandom_range(3, 254), THRESHOLD_RESET};
      foreach (levels[p]) begin
         set_threshold(levels[p]);
         while (sent < (p + 1) * ITEM_BUDGET / 4) query_round();
      end
      set_threshold(0);
      repeat (3) query_round();

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("[lsh_bucket_vote_table] OK");
      end else begin
         $display("[lsh_bucket_vote_table] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/lbvt_pkg.sv
hdl/lbvt_ram.sv
hdl/lbvt_engine.sv
hdl/lsh_bucket_vote_table.sv
dv/lsh_bucket_vote_table_checker.sv
dv/lsh_bucket_vote_table_tb.sv
